// ===== src/pwli_pkg.sv =====
package pwli_pkg;

    localparam int unsigned EFF_W    = 17;
    localparam int unsigned ENERGY_W = 32;
    localparam int unsigned IDX_W    = 8;
    localparam int unsigned NPTS_W   = 9;
    // product of a 17-bit efficiency step and a 32-bit energy offset
    localparam int unsigned PROD_W   = 49;
    localparam int unsigned DCNT_W   = 6;
    localparam logic [EFF_W-1:0] EFF_ONE = 17'd65536;

    typedef enum logic
    {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    typedef struct packed
    {
        logic [0:0]          opcode;
        logic [IDX_W-1:0]    point_index;
        logic [ENERGY_W-1:0] energy;
        logic [EFF_W-1:0]    point_eff;
    } in_item_t;

    typedef struct packed
    {
        logic [EFF_W-1:0] efficiency;
        logic             out_of_range;
    } out_item_t;

    // front to back: head of the command queue
    typedef struct packed
    {
        logic     valid;
        in_item_t item;
    } cmd_head_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_SEARCH,
        ST_SEARCH_CMP,
        ST_RD_LAST,
        ST_RD_FIRST,
        ST_RD_LO,
        ST_RD_HI,
        ST_CHECK,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_ADJ,
        ST_OUT
    } back_state_t;

endpackage

// ===== src/pwli_front.sv =====
module pwli_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  pwli_pkg::in_item_t item,
    output pwli_pkg::cmd_head_t head,
    input  logic               head_pop
);

    pwli_pkg::in_item_t  slot_reg [2];
    logic                wr_ptr_reg, wr_ptr_next;
    logic                rd_ptr_reg, rd_ptr_next;
    logic [1:0]          count_reg, count_next;
    pwli_pkg::in_item_t  clamped;
    logic                do_push;
    logic                do_pop;

    // Saturate the loaded efficiency to one before queueing.
    always_comb
    begin
        clamped = item;
        if (item.point_eff > pwli_pkg::EFF_ONE)
        begin
            clamped.point_eff = pwli_pkg::EFF_ONE;
        end
    end

    assign full    = (count_reg == 2'd2);
    assign do_push = push && !full;
    assign do_pop  = head_pop && (count_reg != 2'd0);

    assign head.valid = (count_reg != 2'd0);
    assign head.item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= clamped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/pwli_div.sv =====
module pwli_div
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [pwli_pkg::PROD_W-1:0]         dividend,
    input  logic [pwli_pkg::ENERGY_W-1:0]       divisor,
    output logic                                busy,
    output logic [pwli_pkg::PROD_W-1:0]         quotient
);

    logic [pwli_pkg::PROD_W-1:0]   q_reg, q_next;
    logic [pwli_pkg::ENERGY_W-1:0] rem_reg, rem_next;
    logic [pwli_pkg::ENERGY_W-1:0] div_reg;
    logic [pwli_pkg::DCNT_W-1:0]   cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic [pwli_pkg::ENERGY_W:0]   trial;

    assign busy     = busy_reg;
    assign quotient = q_reg;

    // One quotient bit per cycle, restoring form.
    always_comb
    begin
        trial     = {rem_reg, q_reg[pwli_pkg::PROD_W-1]};
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            cnt_next  = pwli_pkg::DCNT_W'(pwli_pkg::PROD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = pwli_pkg::ENERGY_W'(trial - {1'b0, div_reg});
                q_next   = {q_reg[pwli_pkg::PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[pwli_pkg::ENERGY_W-1:0];
                q_next   = {q_reg[pwli_pkg::PROD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == pwli_pkg::DCNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

endmodule

// ===== src/pwli_back.sv =====
module pwli_back
#(
    parameter int TABLE_DEPTH = 256
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [pwli_pkg::NPTS_W-1:0]       n_used,
    input  pwli_pkg::cmd_head_t               head,
    output logic                              head_pop,
    output logic                              empty,
    input  logic                              pop,
    output pwli_pkg::out_item_t               result
);

    localparam int AW = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam int MW = pwli_pkg::ENERGY_W + pwli_pkg::EFF_W;

    logic [MW-1:0] mem [TABLE_DEPTH];
    logic [MW-1:0] rdata_reg;
    logic [AW-1:0] raddr;
    logic          mem_we;

    pwli_pkg::back_state_t state_reg, state_next;

    logic [pwli_pkg::NPTS_W-1:0]   lo_reg, lo_next, hi_reg, hi_next, mi_reg, mi_next;
    logic [pwli_pkg::ENERGY_W-1:0] e_reg, e_next;
    logic [pwli_pkg::ENERGY_W-1:0] elast_reg, elast_next, efirst_reg, efirst_next;
    logic [pwli_pkg::ENERGY_W-1:0] elo_reg, elo_next;
    logic [pwli_pkg::EFF_W-1:0]    flo_reg, flo_next;
    logic [pwli_pkg::EFF_W-1:0]    dfm_reg, dfm_next;
    logic [pwli_pkg::ENERGY_W-1:0] den_reg, den_next;
    logic                          neg_reg, neg_next;
    logic [pwli_pkg::PROD_W-1:0]   prod_reg, prod_next;
    pwli_pkg::out_item_t           pend_reg, pend_next;
    pwli_pkg::out_item_t           res_reg, res_next;
    logic                          res_valid_reg, res_valid_next;

    logic [pwli_pkg::ENERGY_W-1:0] rd_e;
    logic [pwli_pkg::EFF_W-1:0]    rd_f;
    logic                          div_start;
    logic                          div_busy;
    logic [pwli_pkg::PROD_W-1:0]   quot;
    logic [pwli_pkg::PROD_W:0]     sum;

    assign rd_e = rdata_reg[MW-1:pwli_pkg::EFF_W];
    assign rd_f = rdata_reg[pwli_pkg::EFF_W-1:0];

    assign empty  = !res_valid_reg;
    assign result = res_reg;

    assign mem_we = (state_reg == pwli_pkg::ST_IDLE) && head.valid
                    && (head.item.opcode == pwli_pkg::OP_LOAD)
                    && (32'(head.item.point_index) < 32'(TABLE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[AW'(head.item.point_index)] <= {head.item.energy, head.item.point_eff};
        end
        rdata_reg <= mem[raddr];
    end

    pwli_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (den_reg),
        .busy     (div_busy),
        .quotient (quot)
    );

    assign sum = {1'b0, quot} + (pwli_pkg::PROD_W+1)'(flo_reg);

    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mi_next        = mi_reg;
        e_next         = e_reg;
        elast_next     = elast_reg;
        efirst_next    = efirst_reg;
        elo_next       = elo_reg;
        flo_next       = flo_reg;
        dfm_next       = dfm_reg;
        den_next       = den_reg;
        neg_next       = neg_reg;
        prod_next      = prod_reg;
        pend_next      = pend_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        head_pop       = 1'b0;
        div_start      = 1'b0;
        raddr          = AW'(mi_reg);

        if (pop && res_valid_reg)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            pwli_pkg::ST_IDLE:
            begin
                if (head.valid)
                begin
                    head_pop = 1'b1;
                    if (head.item.opcode == pwli_pkg::OP_QUERY)
                    begin
                        e_next  = head.item.energy;
                        lo_next = '0;
                        hi_next = n_used - 1'b1;
                        if (n_used < pwli_pkg::NPTS_W'(2))
                        begin
                            pend_next  = '{efficiency: '0, out_of_range: 1'b1};
                            state_next = pwli_pkg::ST_OUT;
                        end
                        else
                        begin
                            state_next = pwli_pkg::ST_SEARCH;
                        end
                    end
                end
            end
            pwli_pkg::ST_SEARCH:
            begin
                if ((hi_reg - lo_reg) > pwli_pkg::NPTS_W'(1))
                begin
                    mi_next    = pwli_pkg::NPTS_W'(({1'b0, hi_reg} + {1'b0, lo_reg}) >> 1);
                    // read the new midpoint at this edge
                    raddr      = AW'(mi_next);
                    state_next = pwli_pkg::ST_SEARCH_CMP;
                end
                else
                begin
                    state_next = pwli_pkg::ST_RD_LAST;
                end
            end
            pwli_pkg::ST_SEARCH_CMP:
            begin
                // rdata holds entry mi, read at the previous edge
                if (e_reg >= rd_e)
                begin
                    lo_next = mi_reg;
                end
                else
                begin
                    hi_next = mi_reg;
                end
                state_next = pwli_pkg::ST_SEARCH;
            end
            pwli_pkg::ST_RD_LAST:
            begin
                raddr      = AW'(n_used - 1'b1);
                state_next = pwli_pkg::ST_RD_FIRST;
            end
            pwli_pkg::ST_RD_FIRST:
            begin
                raddr      = '0;
                elast_next = rd_e;
                state_next = pwli_pkg::ST_RD_LO;
            end
            pwli_pkg::ST_RD_LO:
            begin
                raddr       = AW'(lo_reg);
                efirst_next = rd_e;
                state_next  = pwli_pkg::ST_RD_HI;
            end
            pwli_pkg::ST_RD_HI:
            begin
                raddr      = AW'(lo_reg + 1'b1);
                elo_next   = rd_e;
                flo_next   = rd_f;
                state_next = pwli_pkg::ST_CHECK;
            end
            pwli_pkg::ST_CHECK:
            begin
                // rdata holds the upper segment point
                dfm_next = (rd_f >= flo_reg) ? rd_f - flo_reg : flo_reg - rd_f;
                den_next = (rd_e >= elo_reg) ? rd_e - elo_reg : elo_reg - rd_e;
                neg_next = (rd_f < flo_reg) ^ (rd_e < elo_reg);
                if ((e_reg > elast_reg) || (e_reg < efirst_reg))
                begin
                    pend_next  = '{efficiency: '0, out_of_range: 1'b1};
                    state_next = pwli_pkg::ST_OUT;
                end
                else if (rd_e == elo_reg)
                begin
                    pend_next  = '{efficiency: flo_reg, out_of_range: 1'b0};
                    state_next = pwli_pkg::ST_OUT;
                end
                else
                begin
                    state_next = pwli_pkg::ST_MUL;
                end
            end
            pwli_pkg::ST_MUL:
            begin
                prod_next  = pwli_pkg::PROD_W'(dfm_reg * (e_reg - elo_reg));
                state_next = pwli_pkg::ST_DIV_GO;
            end
            pwli_pkg::ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = pwli_pkg::ST_DIV_WAIT;
            end
            pwli_pkg::ST_DIV_WAIT:
            begin
                if (!div_busy)
                begin
                    state_next = pwli_pkg::ST_ADJ;
                end
            end
            pwli_pkg::ST_ADJ:
            begin
                // apply the signed step and saturate to [0, one]
                pend_next.out_of_range = 1'b0;
                if (neg_reg)
                begin
                    if (quot > pwli_pkg::PROD_W'(flo_reg))
                    begin
                        pend_next.efficiency = '0;
                    end
                    else
                    begin
                        pend_next.efficiency = flo_reg - quot[pwli_pkg::EFF_W-1:0];
                    end
                end
                else if (sum > (pwli_pkg::PROD_W+1)'(pwli_pkg::EFF_ONE))
                begin
                    pend_next.efficiency = pwli_pkg::EFF_ONE;
                end
                else
                begin
                    pend_next.efficiency = sum[pwli_pkg::EFF_W-1:0];
                end
                state_next = pwli_pkg::ST_OUT;
            end
            pwli_pkg::ST_OUT:
            begin
                if (!res_valid_next)
                begin
                    res_next       = pend_reg;
                    res_valid_next = 1'b1;
                    state_next     = pwli_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pwli_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mi_reg     <= mi_next;
        e_reg      <= e_next;
        elast_reg  <= elast_next;
        efirst_reg <= efirst_next;
        elo_reg    <= elo_next;
        flo_reg    <= flo_next;
        dfm_reg    <= dfm_next;
        den_reg    <= den_next;
        neg_reg    <= neg_next;
        prod_reg   <= prod_next;
        pend_reg   <= pend_next;
        res_reg    <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pwli_pkg::ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

// ===== src/piecewise_linear_table_interp.sv =====
// Channel   Direction  Handshake           Beat
// -------   ---------  ------------------  ------------------------------------
// input     in         push / full         item: load point or energy query
// result    out        empty / pop         result: efficiency, out_of_range
// config    in         cfg_valid/cfg_ready cfg_data: number of table points
//
// A load is written from the back end's idle state; a query on a short table
// goes straight to the output state. Other queries run a read and a compare per
// binary-search step (up to eight), four end and segment point reads, a range
// check, one multiply, then start and wait out the 49-step serial divider.
// Reset clears the queues, the sequencer and the point count; table contents
// stay undefined until loaded. Full rises when the 2-deep command queue fills;
// a result waiting on pop stalls only the back end.
module piecewise_linear_table_interp
#(
    parameter int TABLE_DEPTH = 256
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  pwli_pkg::in_item_t                  item,
    output logic                                empty,
    input  logic                                pop,
    output pwli_pkg::out_item_t                 result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pwli_pkg::NPTS_W-1:0]         cfg_data
);

    // largest count the 9-bit register can name, capped at the table depth
    localparam int CAP = (TABLE_DEPTH > 511) ? 511 : TABLE_DEPTH;

    logic [pwli_pkg::NPTS_W-1:0] point_count_reg, point_count_next;
    logic [pwli_pkg::NPTS_W-1:0] n_used;
    pwli_pkg::cmd_head_t         head;
    logic                        head_pop;

    // Take configuration beats at any time; the count takes effect at once,
    // so write it only while no query is in flight.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        point_count_next = point_count_reg;
        if (cfg_valid && cfg_ready)
        begin
            point_count_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= '0;
        end
        else
        begin
            point_count_reg <= point_count_next;
        end
    end

    // Clamp an oversized count to the table depth.
    assign n_used = (point_count_reg > pwli_pkg::NPTS_W'(CAP)) ? pwli_pkg::NPTS_W'(CAP)
                                                                : point_count_reg;

    pwli_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .head     (head),
        .head_pop (head_pop)
    );

    pwli_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .n_used   (n_used),
        .head     (head),
        .head_pop (head_pop),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule

// ===== tb/sv/tb_piecewise_linear_table_interp.sv =====
`timescale 1ns / 1ps

module tb_piecewise_linear_table_interp;

    localparam int DEPTH       = 256;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_WAIT  = 120;
    localparam int CFG_INDEX_POINTS = 0;

    // Golden copy of the lookup table plus the expected-result queue.
    class interp_scoreboard;
        logic [pwli_pkg::ENERGY_W-1:0] energies [DEPTH];
        logic [pwli_pkg::EFF_W-1:0]    effs [DEPTH];
        logic [pwli_pkg::NPTS_W-1:0]   npoints;
        pwli_pkg::out_item_t           pending [$];
        int                            errors;

        function void write_reg(int index, logic [pwli_pkg::NPTS_W-1:0] value);
            if (index == CFG_INDEX_POINTS)
                npoints = value;
        endfunction

        // Work out the expected beat for a query; loads only update the table.
        function void note_input(pwli_pkg::in_item_t it);
            int unsigned n, lo, hi, mi;
            longint elo, ehi, flo, fhi, num, den, res;
            pwli_pkg::out_item_t r;
            if (it.opcode == pwli_pkg::OP_LOAD) begin
                energies[it.point_index] = it.energy;
                effs[it.point_index] = (it.point_eff > pwli_pkg::EFF_ONE) ? pwli_pkg::EFF_ONE
                                                                          : it.point_eff;
                return;
            end
            n = (npoints > DEPTH) ? DEPTH : npoints;
            r.efficiency = '0;
            r.out_of_range = 1'b1;
            if (n >= 2) begin
                lo = 0;
                hi = n - 1;
                while (hi - lo > 1) begin
                    mi = (hi + lo) / 2;
                    if (it.energy >= energies[mi])
                        lo = mi;
                    else
                        hi = mi;
                end
                if (!(it.energy > energies[n-1] || it.energy < energies[0])) begin
                    elo = energies[lo];
                    ehi = energies[lo+1];
                    flo = effs[lo];
                    fhi = effs[lo+1];
                    r.out_of_range = 1'b0;
                    if (ehi == elo)
                        res = flo;
                    else begin
                        num = (fhi - flo) * (longint'(it.energy) - elo);
                        den = ehi - elo;
                        res = flo + num / den;
                        if (res < 0) res = 0;
                        if (res > 65536) res = 65536;
                    end
                    r.efficiency = res[pwli_pkg::EFF_W-1:0];
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(pwli_pkg::out_item_t got);
            pwli_pkg::out_item_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result eff=%0d oor=%0b", $time,
                         got.efficiency, got.out_of_range);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.efficiency !== want.efficiency) begin
                $display("%0t: efficiency expected %0d actual %0d", $time,
                         want.efficiency, got.efficiency);
                errors++;
            end
            if (got.out_of_range !== want.out_of_range) begin
                $display("%0t: out_of_range expected %0b actual %0b", $time,
                         want.out_of_range, got.out_of_range);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    pwli_pkg::in_item_t item = '0;
    logic empty;
    logic pop = 1'b0;
    pwli_pkg::out_item_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [pwli_pkg::NPTS_W-1:0] cfg_data = '0;

    interp_scoreboard sb;
    int cycles = 0;
    logic [pwli_pkg::NPTS_W-1:0] cur_points = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    piecewise_linear_table_interp uut
    (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full), .item(item),
        .empty(empty), .pop(pop), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // Watchdog: abort a hung run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("piecewise_linear_table_interp: mismatch");
            $finish;
        end
    end

    // Result side: random pop stalls, check every accepted beat.
    initial
    begin : result_side
        int gap;
        @(posedge rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (gap != 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
            sb.check_result(result);
        end
    end

    // Send one beat; hold push until full is low at an edge. Push stays high
    // so that a following beat can go back to back.
    task automatic send_beat(pwli_pkg::in_item_t it, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item <= it;
        push <= 1'b1;
        @(posedge clk);
        while (full) @(posedge clk);
        sb.note_input(it);
    endtask

    task automatic load_point(int idx, logic [pwli_pkg::ENERGY_W-1:0] e,
                              logic [pwli_pkg::EFF_W-1:0] f);
        pwli_pkg::in_item_t it;
        it = '0;
        it.opcode = pwli_pkg::OP_LOAD;
        it.point_index = idx[pwli_pkg::IDX_W-1:0];
        it.energy = e;
        it.point_eff = f;
        send_beat(it, $urandom_range(0, 3) == 0);
    endtask

    task automatic query(logic [pwli_pkg::ENERGY_W-1:0] e);
        pwli_pkg::in_item_t it;
        it = '0;
        it.opcode = pwli_pkg::OP_QUERY;
        it.energy = e;
        // Noise in unused fields must not matter.
        it.point_index = pwli_pkg::IDX_W'($urandom());
        it.point_eff = pwli_pkg::EFF_W'($urandom());
        send_beat(it, $urandom_range(0, 3) == 0);
    endtask

    // Drop push, wait for every expected beat, then let the back end settle.
    task automatic drain();
        push <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Write the point count only when idle.
    task automatic set_points(logic [pwli_pkg::NPTS_W-1:0] value);
        drain();
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(CFG_INDEX_POINTS, value);
        cur_points = value;
        cfg_valid <= 1'b0;
    endtask

    // Load a sorted table of n points with random spacing.
    task automatic load_sorted(int n, int unsigned step_max);
        logic [pwli_pkg::ENERGY_W-1:0] e;
        e = $urandom_range(0, 1000);
        for (int i = 0; i < n; i++) begin
            load_point(i, e, pwli_pkg::EFF_W'($urandom_range(0, 70000)));
            e = e + $urandom_range(0, step_max);
        end
    endtask

    function automatic logic [pwli_pkg::ENERGY_W-1:0] pick_energy();
        int n, k;
        n = (cur_points > DEPTH) ? DEPTH : cur_points;
        if (n < 1) return $urandom();
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return sb.energies[k];
            2: return sb.energies[k] + 1;
            default: return sb.energies[k] + $urandom_range(0, 2000);
        endcase
    endfunction

    initial
    begin : stimulus
        int sent, n;
        sb = new();
        sb.npoints = '0;
        sb.errors = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: short table (zero and one point), then a hand-made table.
        query(32'd5);
        load_point(0, 32'd100, 17'd1000);
        set_points(9'd1);
        query(32'd100);
        load_point(1, 32'd100, 17'h1FFFF);   // flat segment, oversized efficiency
        load_point(2, 32'd200, 17'd0);
        load_point(3, 32'hFFFF_FFFF, 17'd65536);
        set_points(9'd4);
        query(32'd100);                      // flat segment's energy; lands on the falling one
        query(32'd150);                      // falling slope
        query(32'd99);                       // below table
        query(32'hFFFF_FFFF);                // top of table
        query(32'd0);
        query(32'h8000_0000);
        // Unsorted table (point 2 below point 1 in energy), then queries on it.
        load_point(0, 32'd0, 17'd0);
        load_point(1, 32'd10, 17'd65536);
        load_point(2, 32'd5, 17'd0);
        load_point(3, 32'd20, 17'd0);
        query(32'd9);
        query(32'd15);
        query(32'd20);

        // Full table, with the count at its maximum and past the depth.
        load_sorted(DEPTH, 32'h00FF_FFFF);
        set_points(9'd256);
        for (int i = 0; i < 8; i++) query(pick_energy());
        set_points(9'd511);
        query(sb.energies[255]);
        query(sb.energies[0]);
        query(32'hFFFF_FFFF);

        sent = 0;
        while (sent < 1000) begin
            // New phase: mostly small tables, occasionally reload or unsort.
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 256)
                                            : $urandom_range(2, 12);
            if ($urandom_range(0, 3) == 0) begin
                load_sorted(n, $urandom_range(0, 3) == 0 ? 32'h0FFF_FFFF : 32'd3000);
                sent += n;
            end
            else if ($urandom_range(0, 4) == 0) begin
                load_point($urandom_range(0, n - 1), $urandom(),
                           pwli_pkg::EFF_W'($urandom()));
                sent++;
            end
            if ($urandom_range(0, 9) == 0) n = $urandom_range(0, 1);
            set_points(n[pwli_pkg::NPTS_W-1:0]);
            for (int q = 0; q < 30; q++) begin
                query(pick_energy());
                sent++;
            end
            // Hold the sender until every expected beat has arrived.
            if ($urandom_range(0, 5) == 0) begin
                push <= 1'b0;
                @(posedge clk);
                while (sb.pending.size() != 0) @(posedge clk);
            end
        end

        drain();
        if (sb.errors == 0)
            $display("piecewise_linear_table_interp: match");
        else
            $display("piecewise_linear_table_interp: mismatch");
        $finish;
    end

endmodule
